### design/battery_voltage_monitor_macros.svh
// Assertion macros used by the battery voltage monitor checker.
// No dependencies; included by the checker file only.
`ifndef BATTERY_VOLTAGE_MONITOR_MACROS_SVH
`define BATTERY_VOLTAGE_MONITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BVM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bvm_pkg.sv
// Shared constants, types and command/status structs of the battery voltage monitor.
// No dependencies; used by every other design file except the assertion macros header.
package bvm_pkg;

   localparam int HISTORY_DEPTH = 8;
   localparam int ADC_BITS      = 10;

   localparam int SAMPLE_W = 10;
   localparam int MV_W     = 16;
   localparam int CHARGE_W = 10;
   localparam int CSR_IDX_W = 2;

   localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int TOTAL_W = MV_W + $clog2(HISTORY_DEPTH);
   localparam int PROD_W  = SAMPLE_W + MV_W;
   localparam int DIV_W   = MV_W + CHARGE_W;
   localparam int ITER_W  = $clog2(DIV_W + 1);

   localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((33'd1 << ADC_BITS) - 33'd1);
   localparam logic [CHARGE_W-1:0] CHARGE_FULL = CHARGE_W'(1000);
   localparam logic [MV_W-1:0] MV_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_MV_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MV   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_MV  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV  = 2'd3;

   localparam logic [MV_W-1:0] RESET_MV_GAIN = 16'd2500;
   localparam logic [MV_W-1:0] RESET_LOW_MV  = 16'd7000;
   localparam logic [MV_W-1:0] RESET_CRIT_MV = 16'd6400;
   localparam logic [MV_W-1:0] RESET_FULL_MV = 16'd8400;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scale;
      logic update;
      logic avg_start;
      logic avg_load;
      logic chg_prep;
      logic chg_start;
      logic chg_load;
      logic out_load;
   } bvm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic chg_direct;
   } bvm_status_type;

endpackage

### design/bvm_if.sv
// Request and response channel interfaces of the battery voltage monitor.
// Depends on bvm_pkg for field widths.
interface bvm_req_if;
   logic                         valid;
   logic                         ready;
   logic [bvm_pkg::SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bvm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bvm_pkg::MV_W-1:0]     filtered_mv;
   logic [bvm_pkg::CHARGE_W-1:0] charge_tenths;
   logic                         low_flag;
   logic                         critical_flag;
   logic                         ok_flag;

   modport source (output valid, output filtered_mv, output charge_tenths,
                   output low_flag, output critical_flag, output ok_flag, input ready);
   modport sink   (input valid, input filtered_mv, input charge_tenths,
                   input low_flag, input critical_flag, input ok_flag, output ready);
endinterface

### design/battery_voltage_monitor.sv
// Top level of the battery voltage monitor: controller plus datapath.
// Depends on bvm_pkg, bvm_if, bvm_ctrl and bvm_datapath.
//
//   Channel   Dir   Handshake          Payload
//   req_bus   in    valid/ready        adc_sample[9:0]
//   rsp_bus   out   valid/ready        filtered_mv, charge_tenths, low/critical/ok flags
//   csr_*     in    csr_wr_en          csr_index[1:0], csr_wdata[15:0]
//
// One request is worked on at a time. The charge division is skipped when the charge level
// is settled by the critical or full threshold alone. The shared one-bit-per-cycle divider
// runs 19 steps for the average and 26 steps for the charge percentage.
// Reset is synchronous and active high; it restores the register defaults and empties
// the history. A finished response waits in the output register, so the next request
// is taken while it is stalled; only a second finished response waits for it to drain.
module battery_voltage_monitor (
   input  logic                          clock,
   input  logic                          reset,
   bvm_req_if.sink                       req_bus,
   bvm_rsp_if.source                     rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [bvm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bvm_pkg::MV_W-1:0]      csr_wdata
);

   bvm_pkg::bvm_cmd_type    cmd;
   bvm_pkg::bvm_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;

   // The controller sequences scaling, ring update, average division and charge
   // division, and holds the response valid flag.
   bvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration registers, the history ring with its
   // running total, the divider and the response payload register.
   bvm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .adc_sample    (req_bus.adc_sample),
      .cmd           (cmd),
      .status        (status),
      .filtered_mv   (rsp_bus.filtered_mv),
      .charge_tenths (rsp_bus.charge_tenths),
      .low_flag      (rsp_bus.low_flag),
      .critical_flag (rsp_bus.critical_flag),
      .ok_flag       (rsp_bus.ok_flag)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

### design/bvm_divider.sv
// Shared restoring divider, one quotient bit per cycle, run for a given bit count.
// Depends on bvm_pkg.
module bvm_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bvm_pkg::ITER_W-1:0] iters,
   input  logic [bvm_pkg::DIV_W-1:0]  dividend,
   input  logic [bvm_pkg::MV_W-1:0]   divisor,
   output logic                       done,
   output logic [bvm_pkg::DIV_W-1:0]  quotient
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [bvm_pkg::ITER_W-1:0] cnt_ff, cnt_in;
   logic [bvm_pkg::MV_W-1:0]   rem_ff, rem_in;
   logic [bvm_pkg::MV_W-1:0]   dvs_ff, dvs_in;
   logic [bvm_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [bvm_pkg::MV_W:0]     rem_shift;
   logic                       fits;

   // The dividend is left aligned, so after the last step the whole register is the quotient.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[bvm_pkg::DIV_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      done_in   = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? bvm_pkg::MV_W'(rem_shift - {1'b0, dvs_ff})
                       : bvm_pkg::MV_W'(rem_shift);
         quo_in = {quo_ff[bvm_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bvm_pkg::ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/bvm_datapath.sv
// Datapath: configuration registers, scaling, history ring, running total,
// threshold logic, output register and the shared divider. Depends on bvm_pkg, bvm_divider.
module bvm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [bvm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bvm_pkg::MV_W-1:0]      csr_wdata,
   input  logic [bvm_pkg::SAMPLE_W-1:0]  adc_sample,
   input  bvm_pkg::bvm_cmd_type          cmd,
   output bvm_pkg::bvm_status_type       status,
   output logic [bvm_pkg::MV_W-1:0]      filtered_mv,
   output logic [bvm_pkg::CHARGE_W-1:0]  charge_tenths,
   output logic                          low_flag,
   output logic                          critical_flag,
   output logic                          ok_flag
);

   localparam int DEPTH = bvm_pkg::HISTORY_DEPTH;

   // Configuration registers.
   logic [bvm_pkg::MV_W-1:0] gain_ff, low_ff, crit_ff, full_ff;

   // Item state.
   logic [bvm_pkg::SAMPLE_W-1:0] sample_ff;
   logic [bvm_pkg::MV_W-1:0]     mv_ff;
   logic [bvm_pkg::MV_W-1:0]     hist_ff [DEPTH];
   logic [bvm_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                         full_hist_ff, full_hist_in;
   logic [bvm_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [bvm_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [bvm_pkg::MV_W-1:0]     avg_ff;
   logic [bvm_pkg::DIV_W-1:0]    diff_prod_ff;
   logic [bvm_pkg::CHARGE_W-1:0] charge_ff;
   logic                         is_low_ff, is_crit_ff;

   // Output register.
   logic [bvm_pkg::MV_W-1:0]     out_mv_ff;
   logic [bvm_pkg::CHARGE_W-1:0] out_charge_ff;
   logic                         out_low_ff, out_crit_ff;

   logic [bvm_pkg::PROD_W-1:0]  scale_prod;
   logic [bvm_pkg::MV_W-1:0]    scaled_mv;
   logic [bvm_pkg::MV_W-1:0]    old_mv;
   logic                        wrap;
   logic                        le_crit, ge_full;
   logic [bvm_pkg::DIV_W-1:0]   chg_prod;
   logic                        div_start, div_done;
   logic [bvm_pkg::ITER_W-1:0]  div_iters;
   logic [bvm_pkg::DIV_W-1:0]   div_dividend, div_quotient;
   logic [bvm_pkg::MV_W-1:0]    div_divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= bvm_pkg::RESET_MV_GAIN;
         low_ff  <= bvm_pkg::RESET_LOW_MV;
         crit_ff <= bvm_pkg::RESET_CRIT_MV;
         full_ff <= bvm_pkg::RESET_FULL_MV;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bvm_pkg::CSR_MV_GAIN: gain_ff <= csr_wdata;
            bvm_pkg::CSR_LOW_MV:  low_ff  <= csr_wdata;
            bvm_pkg::CSR_CRIT_MV: crit_ff <= csr_wdata;
            bvm_pkg::CSR_FULL_MV: full_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Scale, saturate, update the ring and running total, and form the threshold compares and charge product.
   always_comb begin
      scale_prod = bvm_pkg::PROD_W'(sample_ff) * bvm_pkg::PROD_W'(gain_ff);
      scaled_mv  = (|scale_prod[bvm_pkg::PROD_W-1:bvm_pkg::MV_W+8]) ? bvm_pkg::MV_MAX
                                                                    : scale_prod[bvm_pkg::MV_W+7:8];
      // Entries not yet written count as zero.
      old_mv     = full_hist_ff ? hist_ff[slot_ff] : '0;
      total_in   = total_ff - bvm_pkg::TOTAL_W'(old_mv) + bvm_pkg::TOTAL_W'(mv_ff);
      wrap       = slot_ff == bvm_pkg::SLOT_W'(DEPTH - 1);
      slot_in    = wrap ? '0 : slot_ff + 1'b1;
      full_hist_in = full_hist_ff | wrap;
      count_in   = full_hist_in ? bvm_pkg::COUNT_W'(DEPTH)
                                : bvm_pkg::COUNT_W'(slot_ff) + 1'b1;
      le_crit    = avg_ff <= crit_ff;
      ge_full    = avg_ff >= full_ff;
      chg_prod   = bvm_pkg::DIV_W'(avg_ff - crit_ff) * bvm_pkg::DIV_W'(bvm_pkg::CHARGE_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         full_hist_ff <= 1'b0;
         total_ff     <= '0;
      end else if (cmd.update) begin
         slot_ff      <= slot_in;
         full_hist_ff <= full_hist_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) sample_ff <= adc_sample & bvm_pkg::ADC_MASK;
      if (cmd.scale)   mv_ff     <= scaled_mv;
      if (cmd.update) begin
         hist_ff[slot_ff] <= mv_ff;
         count_ff         <= count_in;
      end
      if (cmd.avg_load) begin
         avg_ff <= (|div_quotient[bvm_pkg::DIV_W-1:bvm_pkg::MV_W]) ? bvm_pkg::MV_MAX
                                                                   : div_quotient[bvm_pkg::MV_W-1:0];
      end
      if (cmd.chg_prep) begin
         diff_prod_ff <= chg_prod;
         is_low_ff    <= avg_ff < low_ff;
         is_crit_ff   <= avg_ff < crit_ff;
         charge_ff    <= le_crit ? '0 : bvm_pkg::CHARGE_FULL;
      end
      if (cmd.chg_load) charge_ff <= div_quotient[bvm_pkg::CHARGE_W-1:0];
      if (cmd.out_load) begin
         out_mv_ff     <= avg_ff;
         out_charge_ff <= charge_ff;
         out_low_ff    <= is_low_ff;
         out_crit_ff   <= is_crit_ff;
      end
   end

   // One divider serves the average and the charge division.
   always_comb begin
      div_start = cmd.avg_start | cmd.chg_start;
      if (cmd.avg_start) begin
         div_iters    = bvm_pkg::ITER_W'(bvm_pkg::TOTAL_W);
         div_dividend = bvm_pkg::DIV_W'(total_ff) << (bvm_pkg::DIV_W - bvm_pkg::TOTAL_W);
         div_divisor  = bvm_pkg::MV_W'(count_ff);
      end else begin
         div_iters    = bvm_pkg::ITER_W'(bvm_pkg::DIV_W);
         div_dividend = diff_prod_ff;
         div_divisor  = full_ff - crit_ff;
      end
   end

   bvm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .iters    (div_iters),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.div_done   = div_done;
   assign status.chg_direct = le_crit | ge_full;

   assign filtered_mv   = out_mv_ff;
   assign charge_tenths = out_charge_ff;
   assign low_flag      = out_low_ff;
   assign critical_flag = out_crit_ff;
   assign ok_flag       = ~out_crit_ff;

endmodule

### design/bvm_ctrl.sv
// Controller state machine: sequences one request through the datapath and
// owns the channel handshakes. Depends on bvm_pkg.
module bvm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bvm_pkg::bvm_status_type status,
   output bvm_pkg::bvm_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SCALE     = 4'd1;
   localparam logic [3:0] ST_UPDATE    = 4'd2;
   localparam logic [3:0] ST_AVG_START = 4'd3;
   localparam logic [3:0] ST_AVG_WAIT  = 4'd4;
   localparam logic [3:0] ST_CHG_PREP  = 4'd5;
   localparam logic [3:0] ST_CHG_START = 4'd6;
   localparam logic [3:0] ST_CHG_WAIT  = 4'd7;
   localparam logic [3:0] ST_FINISH    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_AVG_START;
         end
         ST_AVG_START: begin
            cmd.avg_start = 1'b1;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.avg_load = 1'b1;
               state_in     = ST_CHG_PREP;
            end
         end
         ST_CHG_PREP: begin
            cmd.chg_prep = 1'b1;
            state_in     = status.chg_direct ? ST_FINISH : ST_CHG_START;
         end
         ST_CHG_START: begin
            cmd.chg_start = 1'b1;
            state_in      = ST_CHG_WAIT;
         end
         ST_CHG_WAIT: begin
            if (status.div_done) begin
               cmd.chg_load = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/bvm_checker.sv
// Port-level checker for the battery voltage monitor, bound to the top level.
// Depends on bvm_pkg and battery_voltage_monitor_macros.svh.
`include "battery_voltage_monitor_macros.svh"

module bvm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bvm_pkg::MV_W-1:0]     filtered_mv,
   input logic [bvm_pkg::CHARGE_W-1:0] charge_tenths,
   input logic                         critical_flag,
   input logic                         ok_flag
);

   `BVM_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `BVM_ASSERT_IMPLY(a_ok_vs_crit, clock, reset, rsp_valid, ok_flag == !critical_flag, "ok flag disagrees with critical flag")
   `BVM_ASSERT_IMPLY(a_crit_zero, clock, reset, rsp_valid && critical_flag, charge_tenths == '0, "critical response with nonzero charge")
   `BVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(filtered_mv) && $stable(charge_tenths), "stalled response changed")

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .filtered_mv   (rsp_bus.filtered_mv),
   .charge_tenths (rsp_bus.charge_tenths),
   .critical_flag (rsp_bus.critical_flag),
   .ok_flag       (rsp_bus.ok_flag)
);
